[rtl/sdtq_pkg.sv]
package sdtq_pkg;

    localparam int unsigned TimeW  = 48;
    localparam int unsigned DelayW = 32;
    localparam int unsigned TypeW  = 8;
    localparam int unsigned KeyW   = 32;
    localparam int unsigned IfaceW = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_EXPIRE = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_REMOVE  = 2'd2;
    localparam logic [1:0] KIND_CLOSE   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [TimeW-1:0]  deadline;
        logic [TypeW-1:0]  ttype;
        logic [KeyW-1:0]   key;
        logic [IfaceW-1:0] iface;
    } t_payload;

    typedef struct packed {
        logic     valid;
        t_payload data;
    } t_entry;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_POP,
        CMD_REMOVE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd         cmd;
        t_payload          new_data;
        logic [TypeW-1:0]  rm_type;
        logic [KeyW-1:0]   rm_key;
        logic [IfaceW-1:0] rm_iface;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

[rtl/sdtq_cell.sv]
module sdtq_cell import sdtq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_left,
    input  logic       i_left_gt,
    input  logic       i_left_seen,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_gt,
    output logic       o_seen
);

    logic     r_valid;
    t_payload r_data;
    t_entry   n_entry;
    logic     w_match;

    assign o_entry.valid = r_valid;
    assign o_entry.data  = r_data;

    // The new timer goes in front of every entry whose deadline is not earlier.
    assign o_gt    = r_valid && (i_ctrl.new_data.deadline > r_data.deadline);
    assign w_match = r_valid && (r_data.ttype == i_ctrl.rm_type)
                     && (r_data.key == i_ctrl.rm_key) && (r_data.iface == i_ctrl.rm_iface);
    assign o_seen  = i_left_seen || w_match;

    always_comb begin
        n_entry = o_entry;
        case (i_ctrl.cmd)
            CMD_INSERT: begin
                if (!o_gt) begin
                    if (i_left_gt) begin
                        n_entry.valid = 1'b1;
                        n_entry.data  = i_ctrl.new_data;
                    end else begin
                        n_entry = i_left;
                    end
                end
            end
            CMD_POP: begin
                n_entry = i_right;
            end
            CMD_REMOVE: begin
                if (o_seen) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_entry.data;
    end

endmodule

[rtl/sorted_deadline_timer_queue.sv]
// Channel   Direction  Beat content
// s_axis    in         tuser: op; tdata: now, delay, timer_type, key_value, iface_id
// m_axis    out        tuser: kind; tlast: last; tdata: status, exp_type, exp_key,
//                      exp_iface, rearm, rearm_delay
// cfg       in         data: removable_type
//
// An add or a remove first captures the beat in S_IDLE; in S_EXEC the cell chain
// shifts and the result is loaded into the output register.
// An expire pops the due head once a cycle in S_EXEC, while the output is not stalled.
// Reset clears the valid bit of every cell and the output register.
// A stalled output holds the chain; a new beat is taken once the previous one is done.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,  // now, delay, timer_type, key_value, iface_id
    input  logic [1:0]   i_s_axis_tuser,  // op
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,  // status, exp_type, exp_key, exp_iface, rearm,
                                          // rearm_delay, zero fill
    output logic [1:0]   o_m_axis_tuser,  // kind
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data
);

    t_state              r_state, n_state;
    logic [1:0]          r_op;
    logic [TimeW-1:0]    r_now;
    logic [TimeW-1:0]    r_dl;
    logic [DelayW-1:0]   r_delay;
    logic [TypeW-1:0]    r_type;
    logic [KeyW-1:0]     r_key;
    logic [IfaceW-1:0]   r_iface;
    logic [TypeW-1:0]    r_rm_type;

    logic                r_out_valid;
    logic [1:0]          r_out_kind, n_out_kind;
    logic [1:0]          r_out_status, n_out_status;
    t_payload            r_out_exp, n_out_exp;
    logic                r_out_rearm, n_out_rearm;
    logic [TimeW-1:0]    r_out_rdelay, n_out_rdelay;
    logic                r_out_last, n_out_last;
    logic                n_out_valid;
    logic                w_emit;
    logic                w_out_free;
    logic                w_accept;
    logic                w_done;

    logic [TimeW:0]      w_sum;
    t_cell_ctrl          w_ctrl;
    t_entry              w_cell  [DEPTH];
    logic [DEPTH-1:0]    w_gt;
    logic [DEPTH-1:0]    w_seen;
    logic [DEPTH-1:0]    w_valid;
    logic                w_head_due;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_sum = {1'b0, i_s_axis_tdata[47:0]}
                   + {{(TimeW+1-DelayW){1'b0}}, i_s_axis_tdata[79:48]};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_s_axis_tuser;
            r_now   <= i_s_axis_tdata[47:0];
            r_delay <= i_s_axis_tdata[79:48];
            r_type  <= i_s_axis_tdata[87:80];
            r_key   <= i_s_axis_tdata[119:88];
            r_iface <= i_s_axis_tdata[127:120];
            r_dl    <= w_sum[TimeW] ? {TimeW{1'b1}} : w_sum[TimeW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rm_type <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rm_type <= i_cfg_data;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_entry w_left, w_right;
            logic   w_left_gt, w_left_seen;
            if (gi == 0) begin : g_first
                assign w_left      = '0;
                assign w_left_gt   = 1'b1;
                assign w_left_seen = 1'b0;
            end else begin : g_mid
                assign w_left      = w_cell[gi-1];
                assign w_left_gt   = w_gt[gi-1];
                assign w_left_seen = w_seen[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_cell[gi+1];
            end
            sdtq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_left      (w_left),
                .i_left_gt   (w_left_gt),
                .i_left_seen (w_left_seen),
                .i_right     (w_right),
                .o_entry     (w_cell[gi]),
                .o_gt        (w_gt[gi]),
                .o_seen      (w_seen[gi])
            );
            assign w_valid[gi] = w_cell[gi].valid;
        end
    endgenerate

    assign w_head_due = w_cell[0].valid && (w_cell[0].data.deadline <= r_now);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl.cmd               = CMD_HOLD;
        w_ctrl.new_data.deadline = r_dl;
        w_ctrl.new_data.ttype    = r_type;
        w_ctrl.new_data.key      = r_key;
        w_ctrl.new_data.iface    = r_iface;
        w_ctrl.rm_type           = r_rm_type;
        w_ctrl.rm_key            = r_key;
        w_ctrl.rm_iface          = r_iface;
        w_emit                   = 1'b0;
        w_done                   = 1'b0;
        n_out_kind               = KIND_ADD;
        n_out_status             = STAT_OK;
        n_out_exp                = '0;
        n_out_rearm              = 1'b0;
        n_out_rdelay             = '0;
        n_out_last               = 1'b1;
        if (r_state == S_EXEC) begin
            case (r_op)
                OP_ADD: begin
                    w_emit = w_out_free;
                    w_done = w_out_free;
                    if (w_valid[DEPTH-1]) begin
                        n_out_status = STAT_FULL;
                    end else begin
                        if (w_out_free) begin
                            w_ctrl.cmd = CMD_INSERT;
                        end
                        n_out_rearm  = !w_gt[0];
                        n_out_rdelay = w_gt[0] ? '0 : {{(TimeW-DelayW){1'b0}}, r_delay};
                    end
                end
                OP_EXPIRE: begin
                    w_emit = w_out_free;
                    if (w_head_due) begin
                        if (w_out_free) begin
                            w_ctrl.cmd = CMD_POP;
                        end
                        n_out_kind = KIND_EXPIRED;
                        n_out_exp  = w_cell[0].data;
                        n_out_exp.deadline = '0;
                        n_out_last = 1'b0;
                    end else begin
                        w_done       = w_out_free;
                        n_out_kind   = KIND_CLOSE;
                        n_out_rearm  = w_cell[0].valid;
                        n_out_rdelay = w_cell[0].valid ? (w_cell[0].data.deadline - r_now) : '0;
                    end
                end
                OP_REMOVE: begin
                    w_emit     = w_out_free;
                    w_done     = w_out_free;
                    n_out_kind = KIND_REMOVE;
                    if (!w_seen[DEPTH-1]) begin
                        n_out_status = STAT_NOTFOUND;
                    end else begin
                        if (w_out_free) begin
                            w_ctrl.cmd = CMD_REMOVE;
                        end
                        if (w_seen[0] && w_cell[1].valid) begin
                            n_out_rearm = 1'b1;
                            if (w_cell[1].data.deadline > r_now) begin
                                n_out_rdelay = w_cell[1].data.deadline - r_now;
                            end
                        end
                    end
                end
                default: begin
                    w_done = 1'b1;
                end
            endcase
        end
    end

    assign n_out_valid = w_emit || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind   <= n_out_kind;
            r_out_status <= n_out_status;
            r_out_exp    <= n_out_exp;
            r_out_rearm  <= n_out_rearm;
            r_out_rdelay <= n_out_rdelay;
            r_out_last   <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {5'b0, r_out_rdelay, r_out_rearm, r_out_exp.iface,
                              r_out_exp.key, r_out_exp.ttype, r_out_status};

`ifndef SYNTH
    logic [DEPTH-1:0] w_order_ok;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_order
            if (gi == DEPTH - 1) begin : g_end
                assign w_order_ok[gi] = 1'b1;
            end else begin : g_pair
                assign w_order_ok[gi] = !w_cell[gi+1].valid || (w_cell[gi].valid
                    && (w_cell[gi].data.deadline <= w_cell[gi+1].data.deadline));
            end
        end
    endgenerate

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + DEPTH'(1)) & w_valid) == '0)
        else $error("occupied cells do not form a prefix of the chain");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_ok)
        else $error("cell chain is not sorted by deadline");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.cmd == CMD_INSERT) |-> !w_valid[DEPTH-1])
        else $error("insert issued into a full chain");

    a_no_shift_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> (w_ctrl.cmd == CMD_HOLD))
        else $error("chain changed while its result could not be stored");
`endif

endmodule
